@@ hdl/hrp_pkg.sv @@
package hrp_pkg;

  // Field widths
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 16;
  localparam int LENGTH_W = 64;
  localparam int CNT_W    = 13;

  // Receive buffer size; the byte limit never exceeds one less than this
  localparam int BUFFER_BYTES  = 8192;
  localparam int CNT_MAX       = (1 << CNT_W) - 1;
  localparam int LIMIT_CAP_INT = (BUFFER_BYTES - 1 > CNT_MAX) ? CNT_MAX : BUFFER_BYTES - 1;
  localparam logic [CNT_W-1:0] LIMIT_CAP     = CNT_W'(LIMIT_CAP_INT);
  localparam logic [CNT_W-1:0] LIMIT_DEFAULT = CNT_W'(CNT_MAX);

  localparam logic [DATA_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CHAR_ZERO  = 8'h30;

  // One byte step handed to the field parsers
  typedef struct packed {
    logic              en;    // consume this byte
    logic              clr;   // start of a new response: clear first
    logic [DATA_W-1:0] data;
  } hrp_step_t;

  function automatic logic is_ws(input logic [DATA_W-1:0] b);
    return (b == CHAR_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [DATA_W-1:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic [3:0] digit_val(input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] d;
    d = b - CHAR_ZERO;
    return d[3:0];
  endfunction

  function automatic logic [DATA_W-1:0] to_lower(input logic [DATA_W-1:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) ? b + 8'h20 : b;
  endfunction

  // "HTTP/"
  function automatic logic [DATA_W-1:0] prefix_char(input logic [2:0] idx);
    logic [DATA_W-1:0] c;
    unique case (idx)
      3'd0: c = "H";
      3'd1: c = "T";
      3'd2: c = "T";
      3'd3: c = "P";
      3'd4: c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  localparam logic [3:0] NEEDLE_LAST = 4'd14;

  // "content-length:"
  function automatic logic [DATA_W-1:0] needle_char(input logic [3:0] idx);
    logic [DATA_W-1:0] c;
    unique case (idx)
      4'd0:  c = "c";
      4'd1:  c = "o";
      4'd2:  c = "n";
      4'd3:  c = "t";
      4'd4:  c = "e";
      4'd5:  c = "n";
      4'd6:  c = "t";
      4'd7:  c = "-";
      4'd8:  c = "l";
      4'd9:  c = "e";
      4'd10: c = "n";
      4'd11: c = "g";
      4'd12: c = "t";
      4'd13: c = "h";
      4'd14: c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/http_response_header_parser.sv @@
// HTTP response header parser.
// Input channel: one response byte per item (in_data_byte) with in_start_flag
// marking the first byte of a new response; in_start_flag clears all parse state.
// Result channel: one item per response when CR LF CR LF completes (out_outcome 0)
// or when the byte limit is hit first (out_outcome 1, all but header length 0).
// Bytes after a result are dropped until the next start flag.
// Config: cfg_wr_en/cfg_wr_data set the byte limit (capped at buffer size - 1,
// zero acts as one); write it only while the block is idle.
// Timing: one item per cycle sustained while out_stall is low. An item is held in
// the input register, parsed from there, and its result is registered in the
// output register.
// The output register decouples the sides: while it holds an untaken result
// and out_stall is high, in_stall rises once the input register is also full.
// Reset (rst_n low, synchronous) empties both registers, clears parse state and
// sets the limit to 8191.
module http_response_header_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  // byte input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hrp_pkg::DATA_W-1:0]  in_data_byte,
  input  logic                        in_start_flag,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hrp_pkg::STATUS_W-1:0] out_status_code,
  output logic [hrp_pkg::LENGTH_W-1:0] out_content_length,
  output logic                        out_length_seen,
  output logic [hrp_pkg::CNT_W-1:0]   out_header_length,
  output logic                        out_outcome,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [hrp_pkg::CNT_W-1:0]   cfg_wr_data
);
  import hrp_pkg::*;

  logic                in_vld_r;
  logic [DATA_W-1:0]   in_data_r;
  logic                in_start_r;
  logic                advance, fire, proc;
  logic [CNT_W-1:0]    limit_r, lim_eff;
  logic [CNT_W-1:0]    cnt_r, cnt_cur, cnt_nxt;
  logic [1:0]          term_r, term_cur, term_nxt;
  logic                fin_r, fin_cur;
  logic                term_hit, limit_hit;
  logic [DATA_W-1:0]   want;
  hrp_step_t           step;
  logic [STATUS_W-1:0] status_nxt;
  logic [LENGTH_W-1:0] length_nxt;
  logic                seen_nxt;

  logic                out_vld_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [LENGTH_W-1:0] out_length_r;
  logic                out_seen_r;
  logic [CNT_W-1:0]    out_hlen_r;
  logic                out_outcome_r;

  // Handshake: the parse stage moves whenever the output register can take a result
  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  // Apply start clear, then count bytes and track the terminator
  always_comb begin
    cnt_cur  = in_start_r ? '0 : cnt_r;
    term_cur = in_start_r ? 2'd0 : term_r;
    fin_cur  = in_start_r ? 1'b0 : fin_r;
    proc     = fire && !fin_cur;

    lim_eff  = (limit_r > LIMIT_CAP) ? LIMIT_CAP : limit_r;
    if (lim_eff == '0) lim_eff = CNT_W'(1);

    cnt_nxt  = cnt_cur + CNT_W'(1);

    want     = term_cur[0] ? CHAR_LF : CHAR_CR;
    term_hit = 1'b0;
    if (in_data_r == want) begin
      term_hit = (term_cur == 2'd3);
      term_nxt = term_cur + 2'd1;
    end else begin
      term_nxt = (in_data_r == CHAR_CR) ? 2'd1 : 2'd0;
    end
    limit_hit = (cnt_nxt >= lim_eff);

    step.en   = proc;
    step.clr  = in_start_r;
    step.data = in_data_r;
  end

  hrp_status u_status (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .status_nxt (status_nxt)
  );

  hrp_length u_length (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .length_nxt (length_nxt),
    .seen_nxt   (seen_nxt)
  );

  // Load the input register whenever it empties or moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_vld_r || advance) begin
      in_vld_r <= in_valid;
    end
    if (!in_vld_r || advance) begin
      in_data_r  <= in_data_byte;
      in_start_r <= in_start_flag;
    end
  end

  // Hold the limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_DEFAULT;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Advance count, terminator match and finished flag per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      term_r <= 2'd0;
      fin_r  <= 1'b0;
    end else if (proc) begin
      cnt_r  <= cnt_nxt;
      term_r <= term_hit ? 2'd0 : term_nxt;
      fin_r  <= term_hit || limit_hit;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= proc && (term_hit || limit_hit);
    end
    if (advance) begin
      out_hlen_r <= cnt_nxt;
      if (term_hit) begin
        out_status_r  <= status_nxt;
        out_length_r  <= length_nxt;
        out_seen_r    <= seen_nxt;
        out_outcome_r <= 1'b0;
      end else begin
        out_status_r  <= '0;
        out_length_r  <= '0;
        out_seen_r    <= 1'b0;
        out_outcome_r <= 1'b1;
      end
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status_code    = out_status_r;
  assign out_content_length = out_length_r;
  assign out_length_seen    = out_seen_r;
  assign out_header_length  = out_hlen_r;
  assign out_outcome        = out_outcome_r;

endmodule

@@ hdl/hrp_status.sv @@
module hrp_status (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hrp_pkg::hrp_step_t            step,
  output logic [hrp_pkg::STATUS_W-1:0]  status_nxt
);
  import hrp_pkg::*;

  typedef enum logic [1:0] {
    ST_WAIT_SPACE,
    ST_SKIP_WS,
    ST_DIGITS,
    ST_DONE
  } st_phase_t;

  localparam logic [2:0] PFX_DONE = 3'd5;
  localparam logic [2:0] PFX_FAIL = 3'd6;

  st_phase_t             phase_r, phase_nxt, phase_cur;
  logic [2:0]            pidx_r, pidx_nxt, pidx_cur;
  logic [STATUS_W-1:0]   acc_r, acc_nxt, acc_cur;
  logic [STATUS_W+3:0]   acc_wide;

  // Advance prefix match and status digits for one byte
  always_comb begin
    phase_cur = step.clr ? ST_WAIT_SPACE : phase_r;
    pidx_cur  = step.clr ? 3'd0 : pidx_r;
    acc_cur   = step.clr ? '0 : acc_r;

    pidx_nxt  = pidx_cur;
    if (pidx_cur < PFX_DONE) begin
      pidx_nxt = (step.data == prefix_char(pidx_cur)) ? pidx_cur + 3'd1 : PFX_FAIL;
    end

    acc_wide  = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0}
              + {(STATUS_W)'(0), digit_val(step.data)};
    phase_nxt = phase_cur;
    acc_nxt   = acc_cur;
    unique case (phase_cur)
      ST_WAIT_SPACE: begin
        if (step.data == CHAR_SPACE) phase_nxt = ST_SKIP_WS;
      end
      ST_SKIP_WS, ST_DIGITS: begin
        if (!(phase_cur == ST_SKIP_WS && is_ws(step.data))) begin
          if (is_digit(step.data)) begin
            acc_nxt   = (acc_wide[STATUS_W+3:STATUS_W] != '0) ? '1
                                                               : acc_wide[STATUS_W-1:0];
            phase_nxt = ST_DIGITS;
          end else begin
            phase_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: ;
      default: ;
    endcase

    status_nxt = (pidx_nxt == PFX_DONE) ? acc_nxt : '0;
  end

  // Hold state unless a byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ST_WAIT_SPACE;
      pidx_r  <= 3'd0;
      acc_r   <= '0;
    end else if (step.en) begin
      phase_r <= phase_nxt;
      pidx_r  <= pidx_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

@@ hdl/hrp_length.sv @@
module hrp_length (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hrp_pkg::hrp_step_t            step,
  output logic [hrp_pkg::LENGTH_W-1:0]  length_nxt,
  output logic                          seen_nxt
);
  import hrp_pkg::*;

  typedef enum logic [1:0] {
    LN_SEARCH,
    LN_SKIP_WS,
    LN_DIGITS,
    LN_DONE
  } ln_phase_t;

  ln_phase_t             phase_r, phase_nxt, phase_cur;
  logic [3:0]            nidx_r, nidx_nxt, nidx_cur;
  logic [LENGTH_W-1:0]   acc_r, acc_nxt, acc_cur;
  logic [LENGTH_W+3:0]   acc_wide;
  logic [DATA_W-1:0]     low_c;

  // Match the header name, then accumulate the decimal value
  always_comb begin
    phase_cur = step.clr ? LN_SEARCH : phase_r;
    nidx_cur  = step.clr ? 4'd0 : nidx_r;
    acc_cur   = step.clr ? '0 : acc_r;
    low_c     = to_lower(step.data);

    acc_wide  = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0}
              + {(LENGTH_W)'(0), digit_val(step.data)};
    phase_nxt = phase_cur;
    nidx_nxt  = nidx_cur;
    acc_nxt   = acc_cur;
    unique case (phase_cur)
      LN_SEARCH: begin
        if (low_c == needle_char(nidx_cur)) begin
          if (nidx_cur == NEEDLE_LAST) begin
            nidx_nxt  = 4'd0;
            phase_nxt = LN_SKIP_WS;
          end else begin
            nidx_nxt = nidx_cur + 4'd1;
          end
        end else begin
          nidx_nxt = (low_c == needle_char(4'd0)) ? 4'd1 : 4'd0;
        end
      end
      LN_SKIP_WS, LN_DIGITS: begin
        if (!(phase_cur == LN_SKIP_WS && is_ws(step.data))) begin
          if (is_digit(step.data)) begin
            acc_nxt   = (acc_wide[LENGTH_W+3:LENGTH_W] != '0) ? '1
                                                               : acc_wide[LENGTH_W-1:0];
            phase_nxt = LN_DIGITS;
          end else begin
            phase_nxt = LN_DONE;
          end
        end
      end
      LN_DONE: ;
      default: ;
    endcase

    length_nxt = acc_nxt;
    seen_nxt   = (phase_nxt != LN_SEARCH);
  end

  // Hold state unless a byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= LN_SEARCH;
      nidx_r  <= 4'd0;
      acc_r   <= '0;
    end else if (step.en) begin
      phase_r <= phase_nxt;
      nidx_r  <= nidx_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule
